### rtl/core/hdr_pixel_tonemap_srgb_unit_macros.svh
// Assertion macros for the tonemap unit.
// Used by the top level only; empty bodies when SYNTHESIS is defined.
`ifndef HDR_PIXEL_TONEMAP_SRGB_UNIT_MACROS_SVH
`define HDR_PIXEL_TONEMAP_SRGB_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define HDRTM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tonemap assertion failed");
`define HDRTM_ASSERT_NEXT(lbl, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("tonemap assertion failed");
`else
`define HDRTM_ASSERT(lbl, prop)
`define HDRTM_ASSERT_NEXT(lbl, cond, expr)
`endif
`endif

### rtl/core/hdrtm_pkg.sv
// Shared constants, types and elaboration-time tables of the tonemap unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hdrtm_pkg;

    localparam logic [19:0] SAT_LEVEL  = 20'd1044480;  // 255.0 in Q8.12
    localparam logic [16:0] LIN_LIMIT  = 17'd205;      // top of linear sRGB segment
    localparam logic [16:0] T_ONE      = 17'h10000;    // 1.0 in Q1.16
    localparam logic [15:0] GAIN_RESET = 16'd256;
    localparam logic [12:0] ALPHA_ONE  = 13'd4096;
    localparam int DIV_STEPS = 16;
    localparam int CURVE_LAT = 4 + DIV_STEPS;
    localparam int ENC_LAT   = 9;
    localparam int PIPE_LAT  = CURVE_LAT + ENC_LAT;
    localparam int BIG_W     = 296;

    typedef logic [16:0] thr_tab_t [256];
    typedef logic [7:0]  byte_tab_t [256];

    // smallest T with 1.055*(T/65536)^(1/2.4)-0.055 >= (k-0.5)/255, exact in integers
    function automatic thr_tab_t build_thr();
        thr_tab_t tab;
        logic [BIG_W-1:0] c53;
        logic [BIG_W-1:0] rk;
        logic [BIG_W-1:0] p;
        int lo;
        int hi;
        int mid;
        c53 = BIG_W'(1);
        for (int i = 0; i < 12; i++) c53 = c53 * BIG_W'(53805);
        tab[0] = 17'd0;
        for (int k = 1; k < 256; k++) begin
            rk = BIG_W'(1);
            for (int i = 0; i < 12; i++) rk = rk * BIG_W'(200 * k + 2705);
            rk = rk << 80;
            lo = 0;
            hi = 65536;
            for (int it = 0; it < 18; it++) begin
                if (lo < hi) begin
                    mid = (lo + hi) / 2;
                    p = c53;
                    for (int i = 0; i < 5; i++) p = p * BIG_W'(mid);
                    if (p >= rk) hi = mid;
                    else lo = mid + 1;
                end
            end
            tab[k] = 17'(lo);
        end
        return tab;
    endfunction

    // linear segment byte, valid for T up to LIN_LIMIT
    function automatic byte_tab_t build_lin();
        byte_tab_t tab;
        longint v;
        for (int t = 0; t < 256; t++) begin
            v = (longint'(t) * 658920 + 6553600) / 13107200;
            tab[t] = 8'(v);
        end
        return tab;
    endfunction

    localparam thr_tab_t  SRGB_THR = build_thr();
    localparam byte_tab_t LIN_TAB  = build_lin();

endpackage
`default_nettype wire

### rtl/core/hdr_pixel_tonemap_srgb_unit.sv
// Top level of the HDR filmic tonemap and sRGB encode unit.
// Depends on hdrtm_pkg, hdrtm_curve, hdrtm_encode and the macros header.
//
//  channel  | handshake               | word
//  ---------+-------------------------+-----------------------------------------
//  pixel    | pix_valid / pix_stall   | red_in, green_in, blue_in, inverse_opacity_in
//  result   | res_valid / res_stall   | red_out, green_out, blue_out, alpha_out
//  config   | cfg_valid / cfg_ready   | cfg_data (exposure gain, Q8.8)
//
// One pixel per clock unless a stalled result word holds the pipeline. Pixels pass
// exposure, curve, 16-step divider, 8-step sRGB threshold search, output register.
// Reset clears valid bits and sets gain to 1.0. A stalled result word
// freezes the whole pipeline, and pix_stall follows it in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "hdr_pixel_tonemap_srgb_unit_macros.svh"
module hdr_pixel_tonemap_srgb_unit
    import hdrtm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        pix_valid,
    output logic             pix_stall,
    input  wire logic [19:0] red_in,
    input  wire logic [19:0] green_in,
    input  wire logic [19:0] blue_in,
    input  wire logic [12:0] inverse_opacity_in,
    output logic             res_valid,
    input  wire logic        res_stall,
    output logic      [7:0]  red_out,
    output logic      [7:0]  green_out,
    output logic      [7:0]  blue_out,
    output logic      [7:0]  alpha_out,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    logic        en;
    logic [15:0] gain_reg;
    logic [PIPE_LAT-1:0] vld_reg;
    logic [7:0]  alpha_reg [0:PIPE_LAT-1];
    logic [21:0] alpha_acc;
    logic [7:0]  alpha_next;
    logic [16:0] t_red;
    logic [16:0] t_grn;
    logic [16:0] t_blu;

    assign en        = !(vld_reg[PIPE_LAT-1] && res_stall);
    assign pix_stall = !en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
            vld_reg  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                gain_reg <= cfg_data;
            end
            if (en)
            begin
                vld_reg <= {vld_reg[PIPE_LAT-2:0], pix_valid};
            end
        end
    end

    // alpha = round((1 - a) * 255), zero at or above one
    assign alpha_acc  = 22'(ALPHA_ONE - inverse_opacity_in) * 22'd510 + 22'd4096;
    assign alpha_next = (inverse_opacity_in < ALPHA_ONE) ? alpha_acc[20:13] : 8'd0;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            alpha_reg[0] <= alpha_next;
            for (int i = 1; i < PIPE_LAT; i++)
            begin
                alpha_reg[i] <= alpha_reg[i-1];
            end
        end
    end

    hdrtm_curve u_curve_r (.clk(clk), .en(en), .gain(gain_reg), .color(red_in),   .tval(t_red));
    hdrtm_curve u_curve_g (.clk(clk), .en(en), .gain(gain_reg), .color(green_in), .tval(t_grn));
    hdrtm_curve u_curve_b (.clk(clk), .en(en), .gain(gain_reg), .color(blue_in),  .tval(t_blu));

    hdrtm_encode u_enc_r (.clk(clk), .en(en), .tval(t_red), .code(red_out));
    hdrtm_encode u_enc_g (.clk(clk), .en(en), .tval(t_grn), .code(green_out));
    hdrtm_encode u_enc_b (.clk(clk), .en(en), .tval(t_blu), .code(blue_out));

    assign res_valid = vld_reg[PIPE_LAT-1];
    assign alpha_out = alpha_reg[PIPE_LAT-1];

    `HDRTM_ASSERT(a_stall_tracks_out, pix_stall == (res_valid && res_stall))
    `HDRTM_ASSERT_NEXT(a_entry_valid, en, vld_reg[0] == $past(pix_valid))
    `HDRTM_ASSERT_NEXT(a_freeze, !en, $stable(vld_reg) && $stable(alpha_out))

endmodule
`default_nettype wire

### rtl/core/hdrtm_curve.sv
// Per-colour exposure, filmic curve polynomials and 16-step restoring divider.
// Depends on hdrtm_pkg. Advances on en.
`timescale 1ns / 1ps
`default_nettype none
module hdrtm_curve
    import hdrtm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [15:0] gain,
    input  wire logic [19:0] color,
    output logic      [16:0] tval
);

    logic [35:0] prod;
    logic [27:0] scaled;
    logic [19:0] v1_next;
    logic [19:0] v1_reg;
    logic [19:0] v2_reg;
    logic [28:0] a2_reg;
    logic [28:0] b2_reg;
    logic [48:0] num3_reg;
    logic [49:0] den3_reg;
    logic        ge_next;

    logic [49:0] rem_reg [0:DIV_STEPS-1];
    logic [49:0] den_reg [0:DIV_STEPS-1];
    logic [15:0] q_reg   [0:DIV_STEPS];
    logic        ge_reg  [0:DIV_STEPS];

    assign prod    = 36'(color) * 36'(gain);
    assign scaled  = prod[35:8];
    assign v1_next = (scaled > 28'(SAT_LEVEL)) ? SAT_LEVEL : scaled[19:0];
    assign ge_next = {1'b0, num3_reg} >= den3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1_reg     <= v1_next;
            v2_reg     <= v1_reg;
            a2_reg     <= 29'(v1_reg) * 29'd251 + 29'd12288;
            b2_reg     <= 29'(v1_reg) * 29'd243 + 29'd241664;
            num3_reg   <= 49'(v2_reg) * 49'(a2_reg);
            den3_reg   <= 50'(v2_reg) * 50'(b2_reg) + 50'd234881024;
            // ratio at or above one saturates; keep remainder below divisor
            rem_reg[0] <= ge_next ? 50'd0 : {1'b0, num3_reg};
            den_reg[0] <= den3_reg;
            q_reg[0]   <= 16'd0;
            ge_reg[0]  <= ge_next;
        end
    end

    for (genvar j = 1; j <= DIV_STEPS; j++)
    begin : g_div
        logic [50:0] trial;
        logic [50:0] diff;
        logic        take;
        assign trial = {rem_reg[j-1], 1'b0};
        assign take  = trial >= {1'b0, den_reg[j-1]};
        assign diff  = trial - {1'b0, den_reg[j-1]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[j]  <= {q_reg[j-1][14:0], take};
                ge_reg[j] <= ge_reg[j-1];
            end
        end
        if (j < DIV_STEPS)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j] <= take ? diff[49:0] : trial[49:0];
                    den_reg[j] <= den_reg[j-1];
                end
            end
        end
    end

    assign tval = ge_reg[DIV_STEPS] ? T_ONE : {1'b0, q_reg[DIV_STEPS]};

endmodule
`default_nettype wire

### rtl/core/hdrtm_encode.sv
// sRGB encode of a Q1.16 value: linear table or 8-step threshold search.
// Depends on hdrtm_pkg. Advances on en.
`timescale 1ns / 1ps
`default_nettype none
module hdrtm_encode
    import hdrtm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [16:0] tval,
    output logic      [7:0]  code
);

    logic [16:0] t_reg   [0:7];
    logic        lin_reg [0:7];
    logic [7:0]  lb_reg  [0:7];
    logic [7:0]  k_reg   [0:7];
    logic [7:0]  code_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg[0]   <= tval;
            lin_reg[0] <= tval <= LIN_LIMIT;
            lb_reg[0]  <= LIN_TAB[tval[7:0]];
            k_reg[0]   <= 8'd0;
        end
    end

    // one result bit per stage, msb first
    for (genvar s = 1; s <= 8; s++)
    begin : g_srch
        logic [7:0] cand;
        logic [7:0] k_new;
        assign cand  = k_reg[s-1] | (8'h80 >> (s - 1));
        assign k_new = (t_reg[s-1] >= SRGB_THR[cand]) ? cand : k_reg[s-1];
        if (s < 8)
        begin : g_mid
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    k_reg[s]   <= k_new;
                    t_reg[s]   <= t_reg[s-1];
                    lin_reg[s] <= lin_reg[s-1];
                    lb_reg[s]  <= lb_reg[s-1];
                end
            end
        end
        else
        begin : g_last
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    code_reg <= lin_reg[s-1] ? lb_reg[s-1] : k_new;
                end
            end
        end
    end

    assign code = code_reg;

endmodule
`default_nettype wire

### tb/tb.sv
// Testbench for hdr_pixel_tonemap_srgb_unit: random and directed pixels under varied handshakes.
// Depends on hdrtm_pkg and the unit's RTL; the expected bytes come from an exact integer predictor.
`timescale 1ns / 1ps

typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
} tm_pixel_t;

class tonemap_scoreboard;
    tm_pixel_t  pending[$];
    logic [15:0] gain;
    int         errors;

    function new();
        gain   = hdrtm_pkg::GAIN_RESET;
        errors = 0;
    endfunction

    // exact test: encoded T/65536 rounds to at least k
    function automatic bit enc_reaches(logic [16:0] t, int k);
        logic [319:0] lhs;
        logic [319:0] rhs;
        lhs = 320'd1;
        rhs = 320'd1;
        for (int i = 0; i < 5; i++) lhs = lhs * 320'(t);
        for (int i = 0; i < 12; i++) lhs = lhs * 320'd53805;
        for (int i = 0; i < 12; i++) rhs = rhs * 320'(200 * k + 2705);
        rhs = rhs << 80;
        return lhs >= rhs;
    endfunction

    function automatic logic [7:0] encode_channel(logic [19:0] c);
        longint unsigned v;
        longint unsigned num;
        longint unsigned den;
        logic [95:0]     quo;
        logic [16:0]     t;
        int              k;
        v = (longint'(c) * longint'(gain)) >> 8;
        if (v > hdrtm_pkg::SAT_LEVEL) v = hdrtm_pkg::SAT_LEVEL;
        num = v * (251 * v + 12288);
        den = v * (243 * v + 241664) + 234881024;
        if (num >= den) t = hdrtm_pkg::T_ONE;
        else
        begin
            quo = (96'(num) << 16) / 96'(den);
            t   = quo[16:0];
        end
        if (t <= hdrtm_pkg::LIN_LIMIT)
            return 8'((longint'(t) * 658920 + 6553600) / 13107200);
        k = 0;
        for (int b = 128; b != 0; b = b >> 1)
            if (enc_reaches(t, k | b)) k = k | b;
        return 8'(k);
    endfunction

    function void note_pixel(logic [19:0] r, logic [19:0] g, logic [19:0] b, logic [12:0] a);
        tm_pixel_t e;
        e.red   = encode_channel(r);
        e.green = encode_channel(g);
        e.blue  = encode_channel(b);
        e.alpha = (a < hdrtm_pkg::ALPHA_ONE) ? 8'(((4096 - int'(a)) * 510 + 4096) / 8192) : 8'd0;
        pending.push_back(e);
    endfunction

    function void check_result(tm_pixel_t got);
        tm_pixel_t e;
        if (pending.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result word %h", $time, got);
            return;
        end
        e = pending.pop_front();
        if (got.red !== e.red)
        begin
            errors++;
            $display("%0t: red expected %0d actual %0d", $time, e.red, got.red);
        end
        if (got.green !== e.green)
        begin
            errors++;
            $display("%0t: green expected %0d actual %0d", $time, e.green, got.green);
        end
        if (got.blue !== e.blue)
        begin
            errors++;
            $display("%0t: blue expected %0d actual %0d", $time, e.blue, got.blue);
        end
        if (got.alpha !== e.alpha)
        begin
            errors++;
            $display("%0t: alpha expected %0d actual %0d", $time, e.alpha, got.alpha);
        end
    endfunction
endclass

module tb;
    logic        clk;
    logic        rst_n;
    logic        pix_valid;
    logic        pix_stall;
    logic [19:0] red_in;
    logic [19:0] green_in;
    logic [19:0] blue_in;
    logic [12:0] inverse_opacity_in;
    logic        res_valid;
    logic        res_stall;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [7:0]  alpha_out;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    tonemap_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int cycle_count;

    hdr_pixel_tonemap_srgb_unit i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .pix_valid          (pix_valid),
        .pix_stall          (pix_stall),
        .red_in             (red_in),
        .green_in           (green_in),
        .blue_in            (blue_in),
        .inverse_opacity_in (inverse_opacity_in),
        .res_valid          (res_valid),
        .res_stall          (res_stall),
        .red_out            (red_out),
        .green_out          (green_out),
        .blue_out           (blue_out),
        .alpha_out          (alpha_out),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    initial
    begin
        sb                 = new();
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        rst_n              <= 1'b0;
        pix_valid          <= 1'b0;
        red_in             <= '0;
        green_in           <= '0;
        blue_in            <= '0;
        inverse_opacity_in <= '0;
        res_stall          <= 1'b0;
        cfg_valid          <= 1'b0;
        cfg_data           <= '0;
    end

    // result side: random stall, check each accepted word
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            sb.check_result({red_out, green_out, blue_out, alpha_out});
        res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 2000000)
        begin
            $display("FAIL hdr_pixel_tonemap_srgb_unit");
            $finish;
        end
    end

    task automatic send_pixel(logic [19:0] r, logic [19:0] g, logic [19:0] b, logic [12:0] a);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid          <= 1'b1;
        red_in             <= r;
        green_in           <= g;
        blue_in            <= b;
        inverse_opacity_in <= a;
        do @(posedge clk); while (pix_stall);
        sb.note_pixel(r, g, b, a);
    endtask

    task automatic drain_pipe();
        pix_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (hdrtm_pkg::PIPE_LAT + 8) @(posedge clk);
    endtask

    task automatic write_gain(logic [15:0] g);
        drain_pipe();
        cfg_valid <= 1'b1;
        cfg_data  <= g;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.gain = g;
    endtask

    function automatic logic [19:0] pick_color();
        case ($urandom_range(0, 3))
            0: return 20'($urandom_range(0, 1048575));
            1: return 20'($urandom_range(0, 8191));
            2: return 20'($urandom_range(0, 300));
            default: return 20'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic random_pixels(int n);
        for (int i = 0; i < n; i++)
            send_pixel(pick_color(), pick_color(), pick_color(), 13'($urandom_range(0, 8191)));
    endtask

    initial
    begin
        logic [15:0] gains [5];
        gains = '{16'd256, 16'd0, 16'hFFFF, 16'd1, 16'd4096};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset gain, field extremes, linear/power boundary, alpha edges
        send_pixel(20'd0, 20'd0, 20'd0, 13'd0);
        send_pixel(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 13'h1FFF);
        send_pixel(20'd1, 20'd2, 20'd3, 13'd4095);
        send_pixel(20'd4096, 20'd8192, 20'd1044480, 13'd4096);
        send_pixel(20'd20, 20'd40, 20'd60, 13'd2048);
        send_pixel(20'd100, 20'd150, 20'd200, 13'd1);
        send_pixel(20'h55555, 20'hAAAAA, 20'd409600, 13'h0AAA);
        send_pixel(20'hAAAAA, 20'h55555, 20'd12, 13'h1555);
        write_gain(16'hFFFF);
        send_pixel(20'd1, 20'd16, 20'd17, 13'd0);
        send_pixel(20'hFFFFF, 20'd4096, 20'd256, 13'd8191);
        write_gain(16'd0);
        send_pixel(20'hFFFFF, 20'd4096, 20'd1, 13'd100);

        for (int p = 0; p < 4; p++)
        begin
            for (int s = 0; s < 5; s++)
            begin
                case (p)
                    0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                    default: begin send_idle_pct = 33; recv_stall_pct = 33; end
                endcase
                write_gain((s == 4) ? 16'($urandom_range(0, 65535)) : gains[s]);
                random_pixels(57);
            end
        end

        drain_pipe();
        if (sb.errors == 0)
            $display("PASS hdr_pixel_tonemap_srgb_unit");
        else
            $display("FAIL hdr_pixel_tonemap_srgb_unit");
        $finish;
    end
endmodule

### sim.f
+incdir+rtl/core
rtl/core/hdrtm_pkg.sv
rtl/core/hdrtm_curve.sv
rtl/core/hdrtm_encode.sv
rtl/core/hdr_pixel_tonemap_srgb_unit.sv
tb/tb.sv
